// ===== src/ttip_pkg.sv =====
// Shared types, constants and helper functions for the text-to-integer parser.
package ttip_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int MAX_LEN_DEFAULT    = 255;

   localparam int BASE_W  = 6;
   localparam int CHAR_W  = 8;
   localparam int DIGIT_W = 7;
   localparam int VALUE_W = 32;
   localparam int OFFS_W  = 8;
   localparam int PHASE_W = 3;

   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

   localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = 7'd99;

   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7a;
   localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5a;
   localparam logic [CHAR_W-1:0] CH_LOW_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;

   // parse phases
   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LEAD    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SIGNED  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_ZERO    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_HEXMARK = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DIGITS  = 3'd5;

   typedef struct packed {
      logic              starts_string;
      logic [CHAR_W-1:0] char_code;
   } item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] parsed_value;
      logic [OFFS_W-1:0]  end_offset;
      logic               digits_seen;
      logic               cut_short;
   } result_type;

   function automatic logic [DIGIT_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
      logic [DIGIT_W-1:0] d;
      d = NOT_A_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = DIGIT_W'(c - CH_ZERO);
      end else if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
         d = DIGIT_W'(c - CH_LOW_A) + 7'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         d = DIGIT_W'(c - CH_UP_A) + 7'd10;
      end
      return d;
   endfunction

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

// ===== src/ttip_in_stage.sv =====
// Input register stage: captures one word from the request channel.
module ttip_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ttip_pkg::item_type req_item,
   input  logic               advance,
   output logic               item_valid,
   output ttip_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   ttip_pkg::item_type item_ff;

   // hold the word while the parser cannot move it on
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/ttip_parser.sv =====
// Parse state and the per-byte step: sign, prefix, multiply-add, result build.
module ttip_parser #(
   parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_LEN    = ttip_pkg::MAX_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ttip_pkg::BASE_W-1:0]  number_base,
   input  logic                         item_valid,
   input  ttip_pkg::item_type           item,
   input  logic                         advance,
   output logic                         res_valid,
   output ttip_pkg::result_type         res
);

   localparam int POS_W = $clog2(MAX_LEN + 1);

   logic [ttip_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [VALUE_BITS-1:0]        acc_ff, acc_in;
   logic [ttip_pkg::BASE_W-1:0]  wbase_ff, wbase_in;
   logic                         minus_ff, minus_in;
   logic                         any_ff, any_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [ttip_pkg::OFFS_W-1:0]  pre_ff, pre_in;

   logic                         fire;
   logic [ttip_pkg::PHASE_W-1:0] s_phase;
   logic [VALUE_BITS-1:0]        s_acc;
   logic [ttip_pkg::BASE_W-1:0]  s_wbase;
   logic                         s_minus;
   logic                         s_any;
   logic [POS_W-1:0]             s_pos;
   logic [ttip_pkg::OFFS_W-1:0]  s_pre;
   logic [ttip_pkg::CHAR_W-1:0]  c;
   logic [ttip_pkg::DIGIT_W-1:0] digit;
   logic [ttip_pkg::BASE_W-1:0]  wb_take;
   logic [VALUE_BITS-1:0]        mac;
   logic [POS_W-1:0]             pos_inc;
   logic [ttip_pkg::OFFS_W-1:0]  pre_here;
   logic                         digit_ok;
   logic                         sig, take, stop, active, emit, cut;
   logic [VALUE_BITS-1:0]        value;

   assign fire  = item_valid && advance;
   assign c     = item.char_code;
   assign digit = ttip_pkg::char_digit(c);

   // a start byte begins from a fresh state
   always_comb begin
      if (item.starts_string) begin
         s_phase = ttip_pkg::PH_LEAD;
         s_acc   = '0;
         s_wbase = number_base;
         s_minus = 1'b0;
         s_any   = 1'b0;
         s_pos   = '0;
         s_pre   = '0;
      end else begin
         s_phase = phase_ff;
         s_acc   = acc_ff;
         s_wbase = wbase_ff;
         s_minus = minus_ff;
         s_any   = any_ff;
         s_pos   = pos_ff;
         s_pre   = pre_ff;
      end
   end

   // auto base falls back to decimal once the first byte is not a zero
   assign wb_take  = (s_wbase == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_DEC : s_wbase;
   assign mac      = s_acc * VALUE_BITS'(wb_take) + VALUE_BITS'(digit);
   assign pos_inc  = s_pos + POS_W'(1);
   assign pre_here = ttip_pkg::OFFS_W'(pos_inc);
   assign digit_ok = (wb_take >= ttip_pkg::BASE_MIN) && (wb_take <= ttip_pkg::BASE_MAX)
                     && (digit < ttip_pkg::DIGIT_W'(wb_take));

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      wbase_in = wbase_ff;
      minus_in = minus_ff;
      any_in   = any_ff;
      pos_in   = pos_ff;
      pre_in   = pre_ff;
      sig      = 1'b0;
      take     = 1'b0;
      stop     = 1'b0;
      active   = 1'b0;
      emit     = 1'b0;
      cut      = 1'b0;
      if (fire) begin
         phase_in = s_phase;
         acc_in   = s_acc;
         wbase_in = s_wbase;
         minus_in = s_minus;
         any_in   = s_any;
         pos_in   = s_pos;
         pre_in   = s_pre;
         active   = 1'b1;
         case (s_phase)
            ttip_pkg::PH_IDLE: begin
               active = 1'b0;
            end
            ttip_pkg::PH_LEAD: begin
               if (ttip_pkg::is_blank(c)) begin
                  phase_in = ttip_pkg::PH_LEAD;
               end else if (c == ttip_pkg::CH_PLUS || c == ttip_pkg::CH_MINUS) begin
                  minus_in = (c == ttip_pkg::CH_MINUS);
                  phase_in = ttip_pkg::PH_SIGNED;
               end else begin
                  sig = 1'b1;
               end
            end
            ttip_pkg::PH_SIGNED: begin
               sig = 1'b1;
            end
            ttip_pkg::PH_ZERO: begin
               if (c == ttip_pkg::CH_LOW_X || c == ttip_pkg::CH_UP_X) begin
                  wbase_in = ttip_pkg::BASE_HEX;
                  phase_in = ttip_pkg::PH_HEXMARK;
               end else begin
                  take = 1'b1;
               end
            end
            ttip_pkg::PH_HEXMARK: begin
               if (digit < ttip_pkg::DIGIT_W'(ttip_pkg::BASE_HEX)) begin
                  acc_in   = VALUE_BITS'(digit);
                  pre_in   = pre_here;
                  phase_in = ttip_pkg::PH_DIGITS;
               end else begin
                  stop = 1'b1;
               end
            end
            ttip_pkg::PH_DIGITS: begin
               take = 1'b1;
            end
            default: begin
               phase_in = ttip_pkg::PH_IDLE;
               active   = 1'b0;
            end
         endcase

         if (sig) begin
            if ((s_wbase == ttip_pkg::BASE_AUTO || s_wbase == ttip_pkg::BASE_HEX)
                && c == ttip_pkg::CH_ZERO) begin
               wbase_in = (s_wbase == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_OCT : s_wbase;
               acc_in   = '0;
               any_in   = 1'b1;
               pre_in   = pre_here;
               phase_in = ttip_pkg::PH_ZERO;
            end else begin
               wbase_in = wb_take;
               take     = 1'b1;
            end
         end

         if (take) begin
            if (digit_ok) begin
               acc_in   = mac;
               any_in   = 1'b1;
               pre_in   = pre_here;
               phase_in = ttip_pkg::PH_DIGITS;
            end else begin
               stop = 1'b1;
            end
         end

         if (active) begin
            if (stop) begin
               emit = 1'b1;
            end else begin
               pos_in = pos_inc;
               if (pos_inc >= POS_W'(MAX_LEN)) begin
                  emit = 1'b1;
                  cut  = 1'b1;
               end
            end
         end

         if (emit) begin
            phase_in = ttip_pkg::PH_IDLE;
         end
      end
   end

   // negate only when a digit was seen; no digits gives zero
   assign value = !any_in ? '0 : (minus_in ? (~acc_in) + VALUE_BITS'(1) : acc_in);

   assign res_valid        = emit;
   assign res.parsed_value = ttip_pkg::VALUE_W'(value);
   assign res.end_offset   = any_in ? pre_in : '0;
   assign res.digits_seen  = any_in;
   assign res.cut_short    = cut;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ttip_pkg::PH_IDLE;
         acc_ff   <= '0;
         wbase_ff <= '0;
         minus_ff <= 1'b0;
         any_ff   <= 1'b0;
         pos_ff   <= '0;
         pre_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         wbase_ff <= wbase_in;
         minus_ff <= minus_in;
         any_ff   <= any_in;
         pos_ff   <= pos_in;
         pre_ff   <= pre_in;
      end
   end

endmodule

// ===== src/ttip_out_stage.sv =====
// Result register stage: holds one finished word for the response channel.
module ttip_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  ttip_pkg::result_type res,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ttip_pkg::result_type rsp
);

   logic                 valid_ff;
   logic                 valid_in;
   ttip_pkg::result_type rsp_ff;

   // move on when the register is empty or being drained this cycle
   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== src/text_to_integer_parser_core.sv =====
// Top level of the streaming text-to-integer parser.
// One byte enters per cycle while the input register is not held, so a sustained rate
// of one byte per clock holds while the response side is not stalled; the result word
// for a string passes from the input register through the combinational parser step
// into the result register. The per-byte critical path is the accumulator multiply-add
// by the base (VALUE_BITS by 6 bits) followed by the sign negation into the result
// register. The base register (reset 10, 0 for prefix detection) is sampled at each
// string start; csr_ready is always high.
module text_to_integer_parser_core #(
   parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_LEN    = ttip_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_starts_string,
   input  logic [ttip_pkg::CHAR_W-1:0]   req_char_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ttip_pkg::VALUE_W-1:0]  rsp_parsed_value,
   output logic [ttip_pkg::OFFS_W-1:0]   rsp_end_offset,
   output logic                          rsp_digits_seen,
   output logic                          rsp_cut_short,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ttip_pkg::BASE_W-1:0]   csr_number_base
);

   logic [ttip_pkg::BASE_W-1:0] number_base_ff;
   ttip_pkg::item_type          req_item;
   ttip_pkg::item_type          item;
   logic                        item_valid;
   logic                        advance;
   logic                        res_valid;
   ttip_pkg::result_type        res;
   ttip_pkg::result_type        rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= ttip_pkg::BASE_RESET;
      end else if (csr_valid && csr_ready) begin
         number_base_ff <= csr_number_base;
      end
   end

   assign req_item.starts_string = req_starts_string;
   assign req_item.char_code     = req_char_code;

   ttip_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ttip_parser #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_LEN    (MAX_LEN)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .number_base (number_base_ff),
      .item_valid  (item_valid),
      .item        (item),
      .advance     (advance),
      .res_valid   (res_valid),
      .res         (res)
   );

   ttip_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_parsed_value = rsp.parsed_value;
   assign rsp_end_offset   = rsp.end_offset;
   assign rsp_digits_seen  = rsp.digits_seen;
   assign rsp_cut_short    = rsp.cut_short;

endmodule

// ===== src/ttip_checker.sv =====
// Port-level checks for the parser core, bound to the top level.
module ttip_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ttip_pkg::VALUE_W-1:0]  rsp_parsed_value,
   input logic [ttip_pkg::OFFS_W-1:0]   rsp_end_offset,
   input logic                          rsp_digits_seen,
   input logic                          rsp_cut_short
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_parsed_value)
         && $stable(rsp_end_offset) && $stable(rsp_digits_seen) && $stable(rsp_cut_short))
      else $error("ttip: stalled result word changed");

   // no digits means zero value and zero offset
   a_no_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_digits_seen |-> rsp_parsed_value == '0 && rsp_end_offset == '0)
      else $error("ttip: nonzero value or offset without digits");

   // the request side only stalls behind a held result
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("ttip: request stalled with empty result register");

   // a fresh result follows an accepted request word
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("ttip: result word without an accepted request word");

endmodule

bind text_to_integer_parser_core ttip_checker u_ttip_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_parsed_value (rsp_parsed_value),
   .rsp_end_offset   (rsp_end_offset),
   .rsp_digits_seen  (rsp_digits_seen),
   .rsp_cut_short    (rsp_cut_short)
);

// ===== sim/text_to_integer_parser_core_test.sv =====
// Self-checking testbench for the streaming text-to-integer parser core.
`timescale 1ns / 1ps

module text_to_integer_parser_core_test;

   localparam int HOLD_OFF      = 8;
   localparam int QUIET_LIMIT   = 3000;
   localparam int RANDOM_TARGET = 1000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_starts_string = 1'b0;
   logic [ttip_pkg::CHAR_W-1:0]    req_char_code = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [ttip_pkg::VALUE_W-1:0]   rsp_parsed_value;
   logic [ttip_pkg::OFFS_W-1:0]    rsp_end_offset;
   logic                           rsp_digits_seen;
   logic                           rsp_cut_short;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [ttip_pkg::BASE_W-1:0]    csr_number_base = ttip_pkg::BASE_RESET;

   text_to_integer_parser_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_starts_string (req_starts_string),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_parsed_value  (rsp_parsed_value),
      .rsp_end_offset    (rsp_end_offset),
      .rsp_digits_seen   (rsp_digits_seen),
      .rsp_cut_short     (rsp_cut_short),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_number_base   (csr_number_base)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the parser state and the base register
   logic [ttip_pkg::BASE_W-1:0]  base_reg      = ttip_pkg::BASE_RESET;
   logic [ttip_pkg::PHASE_W-1:0] shadow_phase  = ttip_pkg::PH_IDLE;
   logic [ttip_pkg::VALUE_W-1:0] shadow_acc    = '0;
   logic [ttip_pkg::BASE_W-1:0]  shadow_base   = '0;
   logic                         shadow_minus  = 1'b0;
   logic                         shadow_any    = 1'b0;
   int                           shadow_pos    = 0;
   int                           shadow_mark   = 0;

   ttip_pkg::result_type pending_numbers [$];
   logic [ttip_pkg::CHAR_W-1:0] text_bytes [$];

   int  mismatches    = 0;
   int  bytes_sent    = 0;
   int  bytes_parsed  = 0;
   int  strings_begun = 0;
   int  numbers_seen  = 0;
   int  cut_seen      = 0;
   int  base_writes   = 0;
   int  quiet_cycles  = 0;
   bit  tx_calm       = 1'b0;
   bit  rx_calm       = 1'b0;

   function automatic logic [ttip_pkg::DIGIT_W-1:0] digit_value(
      input logic [ttip_pkg::CHAR_W-1:0] c);
      if (c >= ttip_pkg::CH_ZERO && c <= ttip_pkg::CH_NINE)
         return ttip_pkg::DIGIT_W'(c - ttip_pkg::CH_ZERO);
      if (c >= ttip_pkg::CH_LOW_A && c <= ttip_pkg::CH_LOW_Z)
         return ttip_pkg::DIGIT_W'(c - ttip_pkg::CH_LOW_A + 8'd10);
      if (c >= ttip_pkg::CH_UP_A && c <= ttip_pkg::CH_UP_Z)
         return ttip_pkg::DIGIT_W'(c - ttip_pkg::CH_UP_A + 8'd10);
      return ttip_pkg::NOT_A_DIGIT;
   endfunction

   function automatic bit is_space_code(input logic [ttip_pkg::CHAR_W-1:0] c);
      return (c == ttip_pkg::CH_SPACE) || (c >= ttip_pkg::CH_TAB && c <= ttip_pkg::CH_CR);
   endfunction

   // returns 1 when the byte ends the string
   function automatic bit take_digit(input logic [ttip_pkg::CHAR_W-1:0] c, input int at);
      logic [ttip_pkg::DIGIT_W-1:0] d;
      d = digit_value(c);
      if (shadow_base < ttip_pkg::BASE_MIN || shadow_base > ttip_pkg::BASE_MAX
          || d >= ttip_pkg::DIGIT_W'(shadow_base))
         return 1'b1;
      shadow_acc  = shadow_acc * ttip_pkg::VALUE_W'(shadow_base) + ttip_pkg::VALUE_W'(d);
      shadow_any  = 1'b1;
      shadow_mark = at + 1;
      shadow_phase = ttip_pkg::PH_DIGITS;
      return 1'b0;
   endfunction

   function automatic bit take_first(input logic [ttip_pkg::CHAR_W-1:0] c, input int at);
      if ((shadow_base == ttip_pkg::BASE_AUTO || shadow_base == ttip_pkg::BASE_HEX)
          && c == ttip_pkg::CH_ZERO) begin
         if (shadow_base == ttip_pkg::BASE_AUTO) shadow_base = ttip_pkg::BASE_OCT;
         shadow_acc   = '0;
         shadow_any   = 1'b1;
         shadow_mark  = at + 1;
         shadow_phase = ttip_pkg::PH_ZERO;
         return 1'b0;
      end
      if (shadow_base == ttip_pkg::BASE_AUTO) shadow_base = ttip_pkg::BASE_DEC;
      return take_digit(c, at);
   endfunction

   function automatic void queue_number(input logic cut);
      ttip_pkg::result_type r;
      r.parsed_value = !shadow_any ? '0 : (shadow_minus ? -shadow_acc : shadow_acc);
      r.end_offset   = shadow_any ? ttip_pkg::OFFS_W'(shadow_mark) : '0;
      r.digits_seen  = shadow_any;
      r.cut_short    = cut;
      pending_numbers.push_back(r);
      shadow_phase = ttip_pkg::PH_IDLE;
   endfunction

   task automatic parse_byte(input logic st, input logic [ttip_pkg::CHAR_W-1:0] c);
      bit done;
      int at;
      logic [ttip_pkg::DIGIT_W-1:0] d;
      done = 1'b0;
      if (st) begin
         shadow_phase = ttip_pkg::PH_LEAD;
         shadow_acc   = '0;
         shadow_base  = base_reg;
         shadow_minus = 1'b0;
         shadow_any   = 1'b0;
         shadow_pos   = 0;
         shadow_mark  = 0;
         strings_begun++;
      end
      if (shadow_phase == ttip_pkg::PH_IDLE) return;
      bytes_parsed++;
      at = shadow_pos;
      case (shadow_phase)
         ttip_pkg::PH_LEAD: begin
            if (is_space_code(c)) begin
               // keep skipping
            end else if (c == ttip_pkg::CH_PLUS || c == ttip_pkg::CH_MINUS) begin
               shadow_minus = (c == ttip_pkg::CH_MINUS);
               shadow_phase = ttip_pkg::PH_SIGNED;
            end else begin
               done = take_first(c, at);
            end
         end
         ttip_pkg::PH_SIGNED: done = take_first(c, at);
         ttip_pkg::PH_ZERO: begin
            if (c == ttip_pkg::CH_LOW_X || c == ttip_pkg::CH_UP_X) begin
               shadow_base  = ttip_pkg::BASE_HEX;
               shadow_phase = ttip_pkg::PH_HEXMARK;
            end else begin
               done = take_digit(c, at);
            end
         end
         ttip_pkg::PH_HEXMARK: begin
            d = digit_value(c);
            if (d < 7'd16) begin
               shadow_acc   = ttip_pkg::VALUE_W'(d);
               shadow_mark  = at + 1;
               shadow_phase = ttip_pkg::PH_DIGITS;
            end else begin
               done = 1'b1;
            end
         end
         ttip_pkg::PH_DIGITS: done = take_digit(c, at);
         default: begin
            shadow_phase = ttip_pkg::PH_IDLE;
            return;
         end
      endcase
      if (done) begin
         queue_number(1'b0);
         return;
      end
      shadow_pos = at + 1;
      if (shadow_pos >= ttip_pkg::MAX_LEN_DEFAULT) queue_number(1'b1);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // sample at the falling edge; the word is taken at the next rising edge
   always @(negedge clock) begin : rsp_check
      ttip_pkg::result_type want;
      bit moved;
      if (!reset) begin
         moved = (req_valid && !req_stall) || (csr_valid && csr_ready);
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            numbers_seen++;
            if (pending_numbers.size() == 0) begin
               report_mismatch("unexpected word", rsp_parsed_value, '0);
            end else begin
               want = pending_numbers.pop_front();
               if (rsp_parsed_value !== want.parsed_value)
                  report_mismatch("parsed_value", rsp_parsed_value, want.parsed_value);
               if (rsp_end_offset !== want.end_offset)
                  report_mismatch("end_offset", 32'(rsp_end_offset), 32'(want.end_offset));
               if (rsp_digits_seen !== want.digits_seen)
                  report_mismatch("digits_seen", 32'(rsp_digits_seen), 32'(want.digits_seen));
               if (rsp_cut_short !== want.cut_short)
                  report_mismatch("cut_short", 32'(rsp_cut_short), 32'(want.cut_short));
               if (want.cut_short) cut_seen++;
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     quiet_cycles, pending_numbers.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // response back-pressure: runs of ready and stall, mostly short, a few long
   always @(posedge clock) begin : rsp_pacing
      int hold_left;
      int r;
      if (reset || rx_calm) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_stall <= 1'b0;
            hold_left = $urandom_range(0, 7);
         end else if (r < 90) begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(0, 2);
         end else if (r < 97) begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(3, 11);
         end else begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(19, 59);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (tx_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_byte(input logic st, input logic [ttip_pkg::CHAR_W-1:0] c);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_starts_string <= st;
      req_char_code     <= c;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      bytes_sent++;
      parse_byte(st, c);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(i == 0, ttip_pkg::CHAR_W'(s[i]));
   endtask

   // hold the input until every expected word has come back
   task automatic wait_all_numbers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_numbers.size() > 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_all_numbers();
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic write_base(input logic [ttip_pkg::BASE_W-1:0] b);
      bit taken;
      settle();
      csr_valid       <= 1'b1;
      csr_number_base <= b;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      base_reg = b;
      base_writes++;
   endtask

   function automatic logic [ttip_pkg::CHAR_W-1:0] blank_code();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? ttip_pkg::CH_SPACE : ttip_pkg::CH_TAB + ttip_pkg::CHAR_W'(k);
   endfunction

   function automatic logic [ttip_pkg::CHAR_W-1:0] digit_code(input int v);
      if (v < 10) return ttip_pkg::CH_ZERO + ttip_pkg::CHAR_W'(v);
      if ($urandom_range(0, 1) == 0) return ttip_pkg::CH_LOW_A + ttip_pkg::CHAR_W'(v - 10);
      return ttip_pkg::CH_UP_A + ttip_pkg::CHAR_W'(v - 10);
   endfunction

   // mostly well-formed numbers with random content; some noise and some cut off
   task automatic send_random_string();
      int mode;
      int count;
      int radix;
      int keep;
      text_bytes.delete();
      tx_calm = ($urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 99);
      if (mode >= 75 && mode < 90) begin
         count = $urandom_range(1, 8);
         for (int i = 0; i < count; i++)
            send_byte($urandom_range(0, 7) == 0, ttip_pkg::CHAR_W'($urandom_range(0, 255)));
         return;
      end
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < count; i++) text_bytes.push_back(blank_code());
      case ($urandom_range(0, 2))
         1: text_bytes.push_back(ttip_pkg::CH_PLUS);
         2: text_bytes.push_back(ttip_pkg::CH_MINUS);
         default: ;
      endcase
      radix = int'(base_reg);
      if (base_reg == ttip_pkg::BASE_AUTO) begin
         case ($urandom_range(0, 2))
            0: begin
               text_bytes.push_back(ttip_pkg::CH_ZERO);
               text_bytes.push_back($urandom_range(0, 1) ? ttip_pkg::CH_LOW_X
                                                         : ttip_pkg::CH_UP_X);
               radix = 16;
            end
            1: begin
               text_bytes.push_back(ttip_pkg::CH_ZERO);
               radix = 8;
            end
            default: radix = 10;
         endcase
      end else if (base_reg == ttip_pkg::BASE_HEX && $urandom_range(0, 2) == 0) begin
         text_bytes.push_back(ttip_pkg::CH_ZERO);
         text_bytes.push_back($urandom_range(0, 1) ? ttip_pkg::CH_LOW_X : ttip_pkg::CH_UP_X);
      end
      if (radix < 2 || radix > 36) radix = 36;
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (int i = 0; i < count; i++)
         text_bytes.push_back(digit_code($urandom_range(0, radix - 1)));
      if (mode < 75) begin
         case ($urandom_range(0, 3))
            0: text_bytes.push_back(8'h00);
            2: text_bytes.push_back(ttip_pkg::CH_SPACE);
            default: text_bytes.push_back(ttip_pkg::CHAR_W'($urandom_range(0, 255)));
         endcase
      end else begin
         // drop the tail; the next start discards what is left
         keep = $urandom_range(0, text_bytes.size());
         while (text_bytes.size() > keep) void'(text_bytes.pop_back());
      end
      for (int i = 0; i < text_bytes.size(); i++) send_byte(i == 0, text_bytes[i]);
   endtask

   task automatic test_directed();
      send_byte(1'b0, "5");          // no string open: ignored
      send_text(" -42");
      send_byte(1'b0, 8'h00);
      send_text("+9z");
      send_text("7");
      send_byte(1'b1, "x");          // restart mid-string, no digit
      send_byte(1'b1, 8'hff);
      wait_all_numbers();
      write_base(ttip_pkg::BASE_AUTO);
      send_text("0x1g");
      send_text("078");
      send_text("0xg");              // prefix without a hex digit
      write_base(ttip_pkg::BASE_HEX);
      send_text("0XfF.");
      write_base(6'd63);             // radix out of range
      send_text("-5");
      write_base(ttip_pkg::BASE_MAX);
      send_text("zZ!");
   endtask

   task automatic test_length_limit();
      write_base(ttip_pkg::BASE_DEC);
      for (int i = 0; i < 260; i++)
         send_byte(i == 0, (i == 0) ? ttip_pkg::CH_ZERO + 8'd1 : digit_code($urandom_range(0, 9)));
      for (int i = 0; i < 256; i++) send_byte(i == 0, blank_code());
      write_base(ttip_pkg::BASE_MIN);
      send_byte(1'b1, ttip_pkg::CH_MINUS);
      for (int i = 0; i < 260; i++) send_byte(1'b0, digit_code($urandom_range(0, 1)));
   endtask

   task automatic test_random_strings();
      int plan [12];
      int quota;
      plan = '{ttip_pkg::BASE_DEC, ttip_pkg::BASE_AUTO, ttip_pkg::BASE_HEX,
               ttip_pkg::BASE_MIN, ttip_pkg::BASE_MAX, ttip_pkg::BASE_OCT,
               1, 37, 63, ttip_pkg::BASE_AUTO, 0, 0};
      plan[10] = $urandom_range(0, 63);
      plan[11] = $urandom_range(2, 36);
      for (int p = 0; p < 12; p++) begin
         write_base(ttip_pkg::BASE_W'(plan[p]));
         rx_calm = (p % 4 == 3);
         quota = bytes_sent + RANDOM_TARGET / 12;
         while (bytes_sent < quota) begin
            send_random_string();
            if ($urandom_range(0, 40) == 0) wait_all_numbers();
         end
      end
      rx_calm = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_length_limit();
      test_random_strings();
      settle();
      $display("covered %0d strings, %0d bytes sent, %0d parsed, %0d base writes",
               strings_begun, bytes_sent, bytes_parsed, base_writes);
      $display("checked %0d result words, %0d ended by the length limit", numbers_seen, cut_seen);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
